>>> src/bmh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Binary max heap package
// Sizes, entry layout, request and status codes, sequencer states.
// ----------------------------------------------------------------------------
package bmh_pkg;

    localparam int CAPACITY    = 256;
    localparam int ELEM_BITS   = 16;
    localparam int PRIO_BITS   = 16;
    localparam int ADDR_BITS   = $clog2(CAPACITY);
    localparam int CNT_BITS    = $clog2(CAPACITY + 1);
    localparam int ACTION_BITS = 2;
    localparam int STATUS_BITS = 2;

    localparam logic [CNT_BITS-1:0] CNT_CAP = CNT_BITS'(CAPACITY);

    typedef struct packed {
        logic [ELEM_BITS-1:0] elem;
        logic [PRIO_BITS-1:0] prio;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_PEEK = 2'd2
    } t_action;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_POP_RD_ROOT,
        S_POP_RD_LAST,
        S_POP_LAST,
        S_DN_RD_R,
        S_DN_CMP_R,
        S_DN_CMP,
        S_PEEK_RD,
        S_PEEK_CAP,
        S_FIN,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

>>> src/binary_max_heap_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Binary max heap priority queue
// Push, pop and peek on a one-based max heap of element and priority pairs.
// Push sifts the new entry up, pop moves the last entry to the root and
// sifts it down, peek reads the root. One word at a time: busy stays high
// until the result strobe cycle, in which the next word may be accepted.
// A single RAM read port and one shared priority comparator serve all
// steps. The receiver cannot stall.
// Synchronous active-low reset empties the queue; RAM contents are not reset.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue
    import bmh_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [ACTION_BITS-1:0] i_action,
    input  wire logic [ELEM_BITS-1:0]   i_elem,
    input  wire logic [PRIO_BITS-1:0]   i_prio,
    output logic                        o_valid,
    output logic [ELEM_BITS-1:0]        o_elem_out,
    output logic [STATUS_BITS-1:0]      o_status,
    output logic [CNT_BITS-1:0]         o_occupancy
);

    t_state               r_state, n_state;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;
    logic [CNT_BITS-1:0]  r_pos, n_pos;
    logic [CNT_BITS-1:0]  r_lidx, n_lidx;
    logic [CNT_BITS-1:0]  r_bidx, n_bidx;
    t_entry               r_item, n_item;
    t_entry               r_best, n_best;
    logic [ELEM_BITS-1:0] r_res, n_res;
    t_status              r_stat, n_stat;

    logic                 r_o_valid;
    logic [ELEM_BITS-1:0] r_o_elem;
    t_status              r_o_stat;
    logic [CNT_BITS-1:0]  r_o_occ;

    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    t_entry               wr_data;
    logic [ADDR_BITS-1:0] rd_addr;
    t_entry               rd_data;
    logic [ENTRY_BITS-1:0] rd_bits;

    logic [PRIO_BITS-1:0] cmp_a, cmp_b;
    logic                 cmp_gt;

    logic [CNT_BITS-1:0]  pos_m1;
    logic [CNT_BITS-1:0]  parent;
    logic [CNT_BITS-1:0]  parent_m1;
    logic [CNT_BITS-1:0]  cnt_m1;
    logic [CNT_BITS-1:0]  right;
    logic [CNT_BITS:0]    next_left;
    logic [CNT_BITS:0]    next_left_m1;

    bmh_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ENTRY_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_bits)
    );

    assign rd_data = t_entry'(rd_bits);

    assign cmp_gt = cmp_a > cmp_b;

    assign pos_m1       = r_pos - 1'b1;
    assign parent       = r_pos >> 1;
    assign parent_m1    = parent - 1'b1;
    assign cnt_m1       = r_cnt - 1'b1;
    assign right        = r_lidx + 1'b1;
    assign next_left    = {r_bidx, 1'b0};
    assign next_left_m1 = next_left - 1'b1;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_pos   = r_pos;
        n_lidx  = r_lidx;
        n_bidx  = r_bidx;
        n_item  = r_item;
        n_best  = r_best;
        n_res   = r_res;
        n_stat  = r_stat;
        wr_en   = 1'b0;
        wr_addr = pos_m1[ADDR_BITS-1:0];
        wr_data = r_item;
        rd_addr = '0;
        cmp_a   = r_item.prio;
        cmp_b   = rd_data.prio;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_res  = '0;
                    n_stat = ST_OK;
                    case (t_action'(i_action))
                        ACT_PUSH: begin
                            if (r_cnt == CNT_CAP) begin
                                n_stat  = ST_FULL;
                                n_state = S_DONE;
                            end else begin
                                n_cnt   = r_cnt + 1'b1;
                                n_pos   = r_cnt + 1'b1;
                                n_item  = '{elem: i_elem, prio: i_prio};
                                n_state = (r_cnt == '0) ? S_FIN : S_UP_RD;
                            end
                        end
                        ACT_POP: begin
                            if (r_cnt == '0) begin
                                n_stat  = ST_EMPTY;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_POP_RD_ROOT;
                            end
                        end
                        ACT_PEEK: begin
                            if (r_cnt == '0) begin
                                n_stat  = ST_EMPTY;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_PEEK_RD;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_UP_RD: begin
                rd_addr = parent_m1[ADDR_BITS-1:0];
                n_state = S_UP_CMP;
            end
            S_UP_CMP: begin
                cmp_a = r_item.prio;
                cmp_b = rd_data.prio;
                if (cmp_gt) begin
                    wr_en   = 1'b1;
                    wr_data = rd_data;
                    n_pos   = parent;
                    n_state = (parent > CNT_BITS'(1)) ? S_UP_RD : S_FIN;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_POP_RD_ROOT: begin
                rd_addr = '0;
                n_state = S_POP_RD_LAST;
            end
            S_POP_RD_LAST: begin
                rd_addr = cnt_m1[ADDR_BITS-1:0];
                n_res   = rd_data.elem;
                n_state = S_POP_LAST;
            end
            S_POP_LAST: begin
                n_item = rd_data;
                n_cnt  = cnt_m1;
                n_pos  = CNT_BITS'(1);
                if (cnt_m1 == '0) begin
                    n_state = S_DONE;
                end else if (cnt_m1 >= CNT_BITS'(2)) begin
                    rd_addr = ADDR_BITS'(1);
                    n_lidx  = CNT_BITS'(2);
                    n_state = S_DN_RD_R;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DN_RD_R: begin
                n_best = rd_data;
                n_bidx = r_lidx;
                if (right <= r_cnt) begin
                    rd_addr = r_lidx[ADDR_BITS-1:0];
                    n_state = S_DN_CMP_R;
                end else begin
                    n_state = S_DN_CMP;
                end
            end
            S_DN_CMP_R: begin
                cmp_a = rd_data.prio;
                cmp_b = r_best.prio;
                if (cmp_gt) begin
                    n_best = rd_data;
                    n_bidx = right;
                end
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                cmp_a = r_best.prio;
                cmp_b = r_item.prio;
                if (cmp_gt) begin
                    wr_en   = 1'b1;
                    wr_data = r_best;
                    n_pos   = r_bidx;
                    if (next_left <= {1'b0, r_cnt}) begin
                        rd_addr = next_left_m1[ADDR_BITS-1:0];
                        n_lidx  = next_left[CNT_BITS-1:0];
                        n_state = S_DN_RD_R;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_state = S_FIN;
                end
            end
            S_PEEK_RD: begin
                rd_addr = '0;
                n_state = S_PEEK_CAP;
            end
            S_PEEK_CAP: begin
                n_res   = rd_data.elem;
                n_state = S_DONE;
            end
            S_FIN: begin
                wr_en   = 1'b1;
                wr_data = r_item;
                n_state = S_IDLE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_o_valid <= (r_state == S_FIN) || (r_state == S_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_lidx <= n_lidx;
        r_bidx <= n_bidx;
        r_item <= n_item;
        r_best <= n_best;
        r_res  <= n_res;
        r_stat <= n_stat;
        if ((r_state == S_FIN) || (r_state == S_DONE)) begin
            r_o_elem <= r_res;
            r_o_stat <= r_stat;
            r_o_occ  <= r_cnt;
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_o_valid;
    assign o_elem_out  = r_o_elem;
    assign o_status    = r_o_stat;
    assign o_occupancy = r_o_occ;

endmodule
`default_nettype wire

>>> src/bmh_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Heap slot RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bmh_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire
